// ===== sv/bracketed_base64_link_id_extractor_assert.svh =====
`ifndef BRACKETED_BASE64_LINK_ID_EXTRACTOR_ASSERT_SVH
`define BRACKETED_BASE64_LINK_ID_EXTRACTOR_ASSERT_SVH

// same-cycle implication
`define BB64_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bb64 assertion failed");

// next-cycle implication
`define BB64_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bb64 assertion failed");

`endif

// ===== sv/bb64_pkg.sv =====
`timescale 1ns / 1ps

package bb64_pkg;

    typedef enum logic [2:0] {
        CLS_SYM   = 3'd0,
        CLS_SKIP  = 3'd1,
        CLS_OPEN  = 3'd2,
        CLS_AMP   = 3'd3,
        CLS_CLOSE = 3'd4,
        CLS_BAD   = 3'd5
    } bb64_cls_t;

    typedef struct packed {
        logic      last;
        bb64_cls_t cls;
        logic [5:0] sym;
    } bb64_item_t;

    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_OPEN   = 3'd1;
    localparam logic [2:0] ST_NO_CLOSE  = 3'd2;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd3;
    localparam logic [2:0] ST_SHORT     = 3'd4;
    localparam logic [2:0] ST_WRONG_TYP = 3'd5;
    localparam logic [2:0] ST_ZERO_ID   = 3'd6;

    localparam logic [7:0] TYPE_RESET = 8'h02;
    localparam logic [2:0] NEED_BYTES = 3'd5;
    localparam int         OUT_W      = 32;

    function automatic bb64_item_t classify(input logic [7:0] c, input logic last);
        bb64_item_t it;
        it.last = last;
        it.sym  = 6'd0;
        it.cls  = CLS_BAD;
        if (c >= 8'h41 && c <= 8'h5A) begin
            it.cls = CLS_SYM;
            it.sym = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            it.cls = CLS_SYM;
            it.sym = 6'(c - 8'h47);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            it.cls = CLS_SYM;
            it.sym = 6'(c + 8'd4);
        end else if (c == CH_PLUS) begin
            it.cls = CLS_SYM;
            it.sym = 6'd62;
        end else if (c == CH_SLASH) begin
            it.cls = CLS_SYM;
            it.sym = 6'd63;
        end else if (c == CH_OPEN) begin
            it.cls = CLS_OPEN;
        end else if (c == CH_AMP) begin
            it.cls = CLS_AMP;
        end else if (c == CH_CLOSE) begin
            it.cls = CLS_CLOSE;
        end else if (c == CH_PAD || c == CH_SPACE || c == CH_CR || c == CH_LF) begin
            it.cls = CLS_SKIP;
        end
        return it;
    endfunction

endpackage

// ===== sv/bracketed_base64_link_id_extractor.sv =====
`timescale 1ns / 1ps

// Extracts a bracketed base64 link id from a byte stream: one byte per cycle in, one result
// transaction per string (on the byte with s_tlast). Bytes are classified at the input and
// queued in a FIFO_DEPTH-entry FIFO; the parser drains one byte per cycle but holds a last
// byte while an earlier result is untaken, so s_tready only drops when the FIFO fills behind
// a stalled result. m_tvalid rises once a string's last byte is parsed into the output
// register, where the result sits, so input keeps flowing while it waits to be taken.
// expected_type resets to 2; write it over cfg_* only while idle: the block does not enforce it.
module bracketed_base64_link_id_extractor #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] found, [3:1] status, [27:4] item_id, [31:28] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // [7:0] expected_type
);
    import bb64_pkg::*;

    logic [7:0] exp_type_reg;
    logic       fq_valid, fq_full, bq_valid, bq_pop;
    bb64_item_t fq_item, bq_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_type_reg <= TYPE_RESET;
        end else if (cfg_valid) begin
            exp_type_reg <= cfg_data;
        end
    end

    bb64_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (fq_valid),
        .q_item   (fq_item),
        .q_full   (fq_full)
    );

    bb64_fifo #(
        .WIDTH ($bits(bb64_item_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_data  (fq_item),
        .full     (fq_full),
        .rd_valid (bq_valid),
        .rd_data  (bq_item),
        .rd_en    (bq_pop)
    );

    bb64_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (bq_valid),
        .q_item        (bq_item),
        .q_pop         (bq_pop),
        .expected_type (exp_type_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

// ===== sv/bb64_fifo.sv =====
`timescale 1ns / 1ps

module bb64_fifo #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data,
    input  logic             rd_en
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && !full;
    assign pop      = rd_en && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/bb64_front.sv =====
`timescale 1ns / 1ps

module bb64_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] char_code
    input  logic                s_tlast,   // last_char
    output logic                q_valid,
    output bb64_pkg::bb64_item_t q_item,
    input  logic                q_full
);
    import bb64_pkg::*;

    assign s_tready = !q_full;
    assign q_valid  = s_tvalid;
    assign q_item   = classify(s_tdata, s_tlast);

endmodule

// ===== sv/bb64_back.sv =====
`timescale 1ns / 1ps

module bb64_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  bb64_pkg::bb64_item_t q_item,
    output logic                 q_pop,
    input  logic [7:0]           expected_type,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata    // [0] found, [3:1] status, [27:4] item_id
);
    import bb64_pkg::*;

    typedef enum logic [5:0] {
        PH_SEEK       = 6'b000001,
        PH_BRACKET    = 6'b000010,
        PH_DECODE     = 6'b000100,
        PH_CLOSED     = 6'b001000,
        PH_BAD        = 6'b010000,
        PH_BAD_CLOSED = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [5:0]  res_bits_reg, res_bits_next;
    logic [2:0]  res_cnt_reg, res_cnt_next;
    logic [2:0]  dec_cnt_reg, dec_cnt_next;
    logic [7:0]  type_reg, type_next;
    logic [23:0] id_reg, id_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    logic [11:0] acc;
    logic [7:0]  byte_val;
    logic        byte_ok;
    logic [2:0]  status;
    logic        take;

    assign take     = q_valid && (!q_item.last || !out_valid_reg || m_tready);
    assign q_pop    = take;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign acc      = {res_bits_reg, q_item.sym};

    always_comb begin
        phase_next     = phase_reg;
        res_bits_next  = res_bits_reg;
        res_cnt_next   = res_cnt_reg;
        dec_cnt_next   = dec_cnt_reg;
        type_next      = type_reg;
        id_next        = id_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        byte_val       = 8'd0;
        byte_ok        = 1'b0;
        status         = ST_NO_OPEN;

        if (take) begin
            unique case (phase_reg)
                PH_BRACKET: begin
                    if (q_item.cls == CLS_AMP) begin
                        phase_next = PH_DECODE;
                    end else if (q_item.cls != CLS_OPEN) begin
                        phase_next = PH_SEEK;
                    end
                end
                PH_DECODE: begin
                    priority if (q_item.cls == CLS_CLOSE) begin
                        phase_next = PH_CLOSED;
                    end else if (q_item.cls == CLS_SKIP) begin
                        phase_next = PH_DECODE;
                    end else if (q_item.cls == CLS_SYM) begin
                        unique case (res_cnt_reg)
                            3'd2: begin
                                byte_val      = acc[7:0];
                                byte_ok       = 1'b1;
                                res_bits_next = 6'd0;
                                res_cnt_next  = 3'd0;
                            end
                            3'd4: begin
                                byte_val      = acc[9:2];
                                byte_ok       = 1'b1;
                                res_bits_next = {4'd0, acc[1:0]};
                                res_cnt_next  = 3'd2;
                            end
                            3'd6: begin
                                byte_val      = acc[11:4];
                                byte_ok       = 1'b1;
                                res_bits_next = {2'd0, acc[3:0]};
                                res_cnt_next  = 3'd4;
                            end
                            default: begin
                                res_bits_next = q_item.sym;
                                res_cnt_next  = 3'd6;
                            end
                        endcase
                    end else begin
                        phase_next = PH_BAD;
                    end
                end
                PH_CLOSED, PH_BAD_CLOSED: begin
                    phase_next = phase_reg;
                end
                PH_BAD: begin
                    if (q_item.cls == CLS_CLOSE) begin
                        phase_next = PH_BAD_CLOSED;
                    end
                end
                default: begin
                    phase_next = (q_item.cls == CLS_OPEN) ? PH_BRACKET : PH_SEEK;
                end
            endcase

            if (byte_ok) begin
                unique case (dec_cnt_reg)
                    3'd0:    type_next = byte_val;
                    3'd2:    id_next[7:0]   = byte_val;
                    3'd3:    id_next[15:8]  = byte_val;
                    3'd4:    id_next[23:16] = byte_val;
                    default: id_next = id_reg;
                endcase
                if (dec_cnt_reg < NEED_BYTES) begin
                    dec_cnt_next = dec_cnt_reg + 3'd1;
                end
            end

            if (q_item.last) begin
                priority if (phase_next == PH_CLOSED) begin
                    priority if (dec_cnt_next < NEED_BYTES) begin
                        status = ST_SHORT;
                    end else if (type_next != expected_type) begin
                        status = ST_WRONG_TYP;
                    end else if (id_next == 24'd0) begin
                        status = ST_ZERO_ID;
                    end else begin
                        status = ST_OK;
                    end
                end else if (phase_next == PH_BAD_CLOSED) begin
                    status = ST_BAD_CHAR;
                end else if (phase_next == PH_DECODE || phase_next == PH_BAD) begin
                    status = ST_NO_CLOSE;
                end else begin
                    status = ST_NO_OPEN;
                end
                out_valid_next = 1'b1;
                out_data_next  = {4'd0, (status == ST_OK) ? id_next : 24'd0,
                                  status, status == ST_OK};
                phase_next     = PH_SEEK;
                res_bits_next  = 6'd0;
                res_cnt_next   = 3'd0;
                dec_cnt_next   = 3'd0;
                type_next      = 8'd0;
                id_next        = 24'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SEEK;
            res_bits_reg  <= '0;
            res_cnt_reg   <= '0;
            dec_cnt_reg   <= '0;
            type_reg      <= '0;
            id_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            res_bits_reg  <= res_bits_next;
            res_cnt_reg   <= res_cnt_next;
            dec_cnt_reg   <= dec_cnt_next;
            type_reg      <= type_next;
            id_reg        <= id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule

// ===== sv/bb64_checker.sv =====
`timescale 1ns / 1ps
`include "bracketed_base64_link_id_extractor_assert.svh"

module bb64_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import bb64_pkg::*;

    logic [2:0]  st;
    logic [23:0] id;
    logic [3:0]  pad;
    logic        found;
    logic        m_wait;
    logic        s_wait;

    assign st     = m_tdata[3:1];
    assign id     = m_tdata[27:4];
    assign pad    = m_tdata[31:28];
    assign found  = m_tdata[0];
    assign m_wait = m_tvalid && !m_tready;
    assign s_wait = s_tvalid && !s_tready;

    `BB64_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_wait, m_tvalid && $stable(m_tdata))
    `BB64_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_wait, s_tvalid && $stable(s_tdata) && $stable(s_tlast))
    `BB64_ASSERT_IMPLY(a_found_ok, aclk, aresetn, m_tvalid, found == (st == ST_OK))
    `BB64_ASSERT_IMPLY(a_fail_zero, aclk, aresetn, m_tvalid && !found, id == 24'd0)
    `BB64_ASSERT_IMPLY(a_ok_nonzero, aclk, aresetn, m_tvalid && found, id != 24'd0 && pad == 4'd0)

endmodule

bind bracketed_base64_link_id_extractor bb64_checker u_bb64_checker (.*);

// ===== verif/bracketed_base64_link_id_extractor_tb.sv =====
`timescale 1ns / 1ps

module bracketed_base64_link_id_extractor_tb;
    import bb64_pkg::*;

    localparam int LIMIT  = 400000;
    localparam int ITEMS  = 1650;
    localparam int PHASES = 5;
    localparam int SETTLE = 12;
    localparam int DRAIN  = 20;

    typedef enum logic [2:0] {
        SEEK_OPEN   = 3'd0,
        SAW_BRACKET = 3'd1,
        DECODING    = 3'd2,
        CLOSED      = 3'd3,
        BAD_SEEN    = 3'd4,
        BAD_CLOSED  = 3'd5
    } scan_state_t;

    typedef struct packed {
        logic        found;
        logic [2:0]  status;
        logic [23:0] item_id;
    } link_result_t;

    class link_id_scoreboard_t;
        logic [7:0]   want_type;
        scan_state_t  phase;
        logic [7:0]   carry_bits;
        logic [2:0]   carry_len;
        logic [2:0]   nbytes;
        logic [7:0]   type_seen;
        logic [23:0]  id_acc;
        link_result_t expected_q[$];
        int           fails;

        function new();
            want_type = TYPE_RESET;
            fails     = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase      = SEEK_OPEN;
            carry_bits = '0;
            carry_len  = '0;
            nbytes     = '0;
            type_seen  = '0;
            id_acc     = '0;
        endfunction

        // 64 marks a byte outside the alphabet
        function logic [6:0] symbol_of(logic [7:0] c);
            if (c >= "A" && c <= "Z") return 7'(c - "A");
            if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
            if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
            if (c == CH_PLUS) return 7'd62;
            if (c == CH_SLASH) return 7'd63;
            return 7'd64;
        endfunction

        function bit is_skip(logic [7:0] c);
            return c == CH_PAD || c == CH_SPACE || c == CH_CR || c == CH_LF;
        endfunction

        function void store_byte(logic [7:0] b);
            if (nbytes == 0) type_seen = b;
            else if (nbytes >= 2 && nbytes <= 4) id_acc |= 24'(b) << (8 * (nbytes - 2));
            if (nbytes < NEED_BYTES) nbytes++;
        endfunction

        function void decode(logic [7:0] c);
            logic [6:0]  v;
            logic [11:0] acc;
            logic [2:0]  sh;
            if (c == CH_CLOSE) begin
                phase = CLOSED;
                return;
            end
            if (is_skip(c)) return;
            v = symbol_of(c);
            if (v[6]) begin
                phase = BAD_SEEN;
                return;
            end
            if (carry_len >= 2) begin
                sh  = carry_len - 3'd2;
                acc = {carry_bits[5:0], v[5:0]};
                store_byte(8'(acc >> sh));
                carry_bits = 8'(acc & ((12'd1 << sh) - 12'd1));
                carry_len  = sh;
            end else begin
                carry_bits = {2'b00, v[5:0]};
                carry_len  = 3'd6;
            end
        endfunction

        function void note_input(logic [7:0] c, logic last);
            link_result_t r;
            case (phase)
                SAW_BRACKET: begin
                    if (c == CH_AMP) phase = DECODING;
                    else if (c != CH_OPEN) phase = SEEK_OPEN;
                end
                DECODING: decode(c);
                CLOSED, BAD_CLOSED: ;
                BAD_SEEN: begin
                    if (c == CH_CLOSE) phase = BAD_CLOSED;
                end
                default: phase = (c == CH_OPEN) ? SAW_BRACKET : SEEK_OPEN;
            endcase
            if (!last) return;
            r.item_id = '0;
            if (phase == CLOSED) begin
                if (nbytes < NEED_BYTES) r.status = ST_SHORT;
                else if (type_seen != want_type) r.status = ST_WRONG_TYP;
                else if (id_acc == 0) r.status = ST_ZERO_ID;
                else begin
                    r.status  = ST_OK;
                    r.item_id = id_acc;
                end
            end else if (phase == BAD_CLOSED) begin
                r.status = ST_BAD_CHAR;
            end else if (phase == DECODING || phase == BAD_SEEN) begin
                r.status = ST_NO_CLOSE;
            end else begin
                r.status = ST_NO_OPEN;
            end
            r.found = (r.status == ST_OK);
            expected_q.insert(expected_q.size(), r);
            clear_parse();
        endfunction

        function void check_result(logic [31:0] d);
            link_result_t want;
            if (expected_q.size() == 0) begin
                $error("result transaction with none expected: %h", d);
                fails++;
                return;
            end
            want = expected_q.pop_front();
            if (d[0] !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, d[0]);
                fails++;
            end
            if (d[3:1] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, d[3:1]);
                fails++;
            end
            if (d[27:4] !== want.item_id) begin
                $error("item_id: expected %h, got %h", want.item_id, d[27:4]);
                fails++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    link_id_scoreboard_t sb;
    logic [7:0] line_q[$];
    int         bytes_sent  = 0;
    int         src_quiet   = 0;
    int         sink_quiet  = 0;
    int         cycle_count = 0;

    bracketed_base64_link_id_extractor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // occasional runs of back-to-back transactions
    function automatic int draw_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    function automatic void add_char(input logic [7:0] c);
        line_q.insert(line_q.size(), c);
    endfunction

    function automatic logic [7:0] b64_char(logic [5:0] v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 62) ? CH_PLUS : CH_SLASH;
    endfunction

    function automatic void put_sym(logic [5:0] v, bit sprinkle);
        if (sprinkle && $urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
                0: add_char(CH_PAD);
                1: add_char(CH_SPACE);
                2: add_char(CH_CR);
                default: add_char(CH_LF);
            endcase
        end
        add_char(b64_char(v));
    endfunction

    function automatic void push_b64(input logic [7:0] raw[$], input bit sprinkle);
        logic [15:0] acc;
        int          nbits;
        int          nchars;
        acc    = '0;
        nbits  = 0;
        nchars = 0;
        foreach (raw[i]) begin
            acc   = {acc[7:0], raw[i]};
            nbits += 8;
            while (nbits >= 6) begin
                nbits -= 6;
                put_sym(6'(acc >> nbits), sprinkle);
                nchars++;
            end
        end
        if (nbits > 0) begin
            put_sym(6'(acc << (6 - nbits)), sprinkle);
            nchars++;
        end
        if (sprinkle && $urandom_range(0, 1) == 1) begin
            while (nchars % 4 != 0) begin
                add_char(CH_PAD);
                nchars++;
            end
        end
    endfunction

    function automatic logic [7:0] pick_bad();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (sb.symbol_of(c) < 64 || sb.is_skip(c) || c == CH_CLOSE);
        return c;
    endfunction

    function automatic void build_link();
        logic [7:0] raw[$];
        int         n;
        int         pick;
        int         body;
        line_q.delete();
        repeat ($urandom_range(0, 3)) add_char(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 5) == 0) add_char(CH_OPEN);
        add_char(CH_OPEN);
        add_char(CH_AMP);
        body = line_q.size();
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : $urandom_range(5, 6);
        for (int i = 0; i < n; i++) raw.insert(raw.size(), 8'($urandom_range(0, 255)));
        if (n > 0 && $urandom_range(0, 3) != 0) raw[0] = sb.want_type;
        if (n > 4 && $urandom_range(0, 7) == 0) begin
            raw[2] = '0;
            raw[3] = '0;
            raw[4] = '0;
        end
        push_b64(raw, $urandom_range(0, 2) == 0);
        pick = $urandom_range(0, 19);
        if (pick < 2) line_q.insert($urandom_range(body, line_q.size()), pick_bad());
        if (pick < 2 || pick > 3) add_char(CH_CLOSE);
        repeat ($urandom_range(0, 2)) add_char(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_noise();
        line_q.delete();
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 7))
                0: add_char(CH_OPEN);
                1: add_char(CH_AMP);
                2: add_char(CH_CLOSE);
                default: add_char(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic l);
        int gap;
        gap = draw_gap(src_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(c, l);
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
        bytes_sent += line_q.size();
    endtask

    task automatic write_type(input logic [7:0] v);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid    <= 1'b0;
        sb.want_type = v;
    endtask

    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_gap(sink_quiet);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_result(m_tdata);
        end
    end

    initial begin
        logic [7:0] raw[$];
        logic [7:0] next_type;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no opener
        line_q = '{"q"};
        send_line();
        // doubled bracket, embedded space, byte after the closer
        raw    = '{8'h02, 8'h11, 8'h34, 8'h12, 8'hAB};
        line_q = '{CH_OPEN, CH_OPEN, CH_AMP};
        push_b64(raw, 1'b0);
        line_q.insert(6, CH_SPACE);
        add_char(CH_CLOSE);
        add_char("x");
        send_line();
        // high byte is not in the alphabet
        line_q = '{CH_OPEN, CH_AMP, 8'hFF, CH_CLOSE};
        send_line();
        // no closer
        line_q = '{CH_OPEN, CH_AMP, "A"};
        send_line();
        // closed with nothing decoded
        line_q = '{CH_OPEN, CH_AMP, CH_CLOSE};
        send_line();

        bytes_sent = 0;
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                case (p)
                    1: next_type = 8'h00;
                    2: next_type = 8'hFF;
                    3: next_type = 8'($urandom_range(0, 255));
                    default: next_type = TYPE_RESET;
                endcase
                write_type(next_type);
            end
            while (bytes_sent < (p + 1) * ITEMS / PHASES) begin
                if ($urandom_range(0, 9) < 8) build_link();
                else build_noise();
                send_line();
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (sb.fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
